FILE: hdl/thb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thb_pkg
// shared constants, request codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package thb_pkg;

	localparam int MAX_BUCKETS = 64;
	localparam int NUM_HIST    = 3;
	localparam int BKT_W       = $clog2(MAX_BUCKETS);
	localparam int HIST_W      = 2;
	localparam int ADDR_W      = HIST_W + BKT_W;
	localparam int MEM_DEPTH   = NUM_HIST * MAX_BUCKETS;
	localparam int USED_W      = 7;
	localparam int DATA_W      = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;

	// request codes
	localparam logic [1:0] REQ_RECORD = 2'd0;
	localparam logic [1:0] REQ_WRITE  = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USED0  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USED1  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_USED2  = 2'd3;

	typedef struct packed {
		logic load;       // latch request fields
		logic decode;     // init result and search bounds
		logic thr_wr;     // store threshold word
		logic hist_clr;   // clear counters of histogram
		logic srch_rd;    // read threshold at midpoint
		logic srch_upd;   // narrow search window
		logic srch_end;   // bucket found
		logic rep_rd_lo;  // read previous threshold and counter
		logic rep_rd_hi;  // lower bound, total; read own threshold
		logic rep_fin;    // upper bound, counter write back
	} thb_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       bad_metric;
		logic       hist_on;
		logic       sel_beyond;
		logic       search_more;
	} thb_stat_t;

endpackage
`default_nettype wire

FILE: hdl/thb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thb_ctrl
// request sequencer: decode, binary search steps, bucket report, result beat
// ----------------------------------------------------------------------------
module thb_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire thb_pkg::thb_stat_t stat,
	output thb_pkg::thb_cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_SRCH = 3'd2;
	localparam logic [2:0] ST_SCMP = 3'd3;
	localparam logic [2:0] ST_RDLO = 3'd4;
	localparam logic [2:0] ST_RDHI = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DEC;
				end
			end
			ST_DEC: begin
				cmd.decode = 1'b1;
				state_nxt  = ST_OUT;
				if (!stat.bad_metric) begin
					case (stat.req)
						thb_pkg::REQ_WRITE: cmd.thr_wr = 1'b1;
						thb_pkg::REQ_CLEAR: cmd.hist_clr = 1'b1;
						thb_pkg::REQ_RECORD: begin
							if (stat.hist_on)
								state_nxt = ST_SRCH;
						end
						default: begin
							if (stat.hist_on && !stat.sel_beyond)
								state_nxt = ST_RDLO;
						end
					endcase
				end
			end
			ST_SRCH: begin
				if (stat.search_more) begin
					cmd.srch_rd = 1'b1;
					state_nxt   = ST_SCMP;
				end else begin
					cmd.srch_end = 1'b1;
					state_nxt    = ST_RDLO;
				end
			end
			ST_SCMP: begin
				cmd.srch_upd = 1'b1;
				state_nxt    = ST_SRCH;
			end
			ST_RDLO: begin
				cmd.rep_rd_lo = 1'b1;
				state_nxt     = ST_RDHI;
			end
			ST_RDHI: begin
				cmd.rep_rd_hi = 1'b1;
				state_nxt     = ST_FIN;
			end
			ST_FIN: begin
				cmd.rep_fin = 1'b1;
				state_nxt   = ST_OUT;
			end
			ST_OUT: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_OUT);

endmodule
`default_nettype wire

FILE: hdl/thb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thb_datapath
// threshold and counter memories, search window, result registers
// ----------------------------------------------------------------------------
module thb_datapath (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire thb_pkg::thb_cmd_t                      cmd,
	output thb_pkg::thb_stat_t                          stat,
	input  wire logic [thb_pkg::NUM_HIST-1:0]           en_mask,
	input  wire logic [thb_pkg::NUM_HIST-1:0][thb_pkg::USED_W-1:0] used_cfg,
	input  wire logic [thb_pkg::NUM_HIST-1:0]           cfg_clr_mask,
	input  wire logic [1:0]                             req_type,
	input  wire logic [thb_pkg::HIST_W-1:0]             metric,
	input  wire logic [thb_pkg::DATA_W-1:0]             sample_value,
	input  wire logic [thb_pkg::DATA_W-1:0]             add_amount,
	input  wire logic [thb_pkg::BKT_W-1:0]              bucket_sel,
	output logic [thb_pkg::BKT_W-1:0]                   bucket_index,
	output logic [thb_pkg::DATA_W-1:0]                  lower_bound,
	output logic [thb_pkg::DATA_W-1:0]                  upper_bound,
	output logic [thb_pkg::DATA_W-1:0]                  bucket_total,
	output logic                                        is_disabled
);

	// latched request
	logic [1:0]                     req_q;
	logic [thb_pkg::HIST_W-1:0]     m_q;
	logic [thb_pkg::DATA_W-1:0]     val_q;
	logic [thb_pkg::DATA_W-1:0]     amt_q;
	logic [thb_pkg::BKT_W-1:0]      sel_q;

	// search window and chosen bucket
	logic [thb_pkg::BKT_W-1:0]      lo_q, hi_q, b_q;

	// memories
	logic [thb_pkg::DATA_W-1:0]     thr_mem [0:thb_pkg::MEM_DEPTH-1];
	logic [thb_pkg::DATA_W-1:0]     cnt_mem [0:thb_pkg::MEM_DEPTH-1];
	logic [thb_pkg::DATA_W-1:0]     thr_rdata_q, cnt_rdata_q;
	logic [thb_pkg::NUM_HIST-1:0][thb_pkg::MAX_BUCKETS-1:0] vld_q;

	logic                           bad_m;
	logic [thb_pkg::USED_W-1:0]     used_raw, used;
	logic                           on;
	logic [thb_pkg::BKT_W:0]        mid_sum;
	logic [thb_pkg::BKT_W-1:0]      mid;
	logic [thb_pkg::BKT_W-1:0]      b_prev;
	logic [thb_pkg::ADDR_W-1:0]     thr_raddr;
	logic [thb_pkg::ADDR_W-1:0]     cnt_addr;
	logic                           is_rec;
	logic [thb_pkg::DATA_W-1:0]     cnt_cur;
	logic [thb_pkg::BKT_W:0]        b_next;

	assign bad_m    = (m_q >= thb_pkg::HIST_W'(thb_pkg::NUM_HIST));
	assign used_raw = bad_m ? thb_pkg::USED_W'(1) : used_cfg[m_q];
	assign on       = !bad_m && en_mask[m_q];
	assign is_rec   = (req_q == thb_pkg::REQ_RECORD);

	// clip buckets in use to 1..MAX_BUCKETS
	always_comb begin
		used = used_raw;
		if (used_raw == '0)
			used = thb_pkg::USED_W'(1);
		else if (used_raw > thb_pkg::USED_W'(thb_pkg::MAX_BUCKETS))
			used = thb_pkg::USED_W'(thb_pkg::MAX_BUCKETS);
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[thb_pkg::BKT_W:1];
	assign b_prev  = b_q - thb_pkg::BKT_W'(1);
	assign b_next  = {1'b0, b_q} + (thb_pkg::BKT_W+1)'(1);

	always_comb begin
		thr_raddr = {m_q, b_q};
		if (cmd.srch_rd)
			thr_raddr = {m_q, mid};
		else if (cmd.rep_rd_lo)
			thr_raddr = {m_q, b_prev};
	end
	assign cnt_addr = {m_q, b_q};
	assign cnt_cur  = vld_q[m_q][b_q] ? cnt_rdata_q : '0;

	assign stat.req         = req_q;
	assign stat.bad_metric  = bad_m;
	assign stat.hist_on     = on;
	assign stat.sel_beyond  = ({1'b0, sel_q} >= used);
	assign stat.search_more = (lo_q < hi_q);

	// threshold memory, one read port
	always_ff @(posedge clk) begin
		if (cmd.thr_wr)
			thr_mem[{m_q, sel_q}] <= val_q;
		thr_rdata_q <= thr_mem[thr_raddr];
	end

	// counter memory, read-modify-write
	always_ff @(posedge clk) begin
		if (cmd.rep_fin && is_rec)
			cnt_mem[cnt_addr] <= bucket_total;
		cnt_rdata_q <= cnt_mem[cnt_addr];
	end

	// counter valid bits: a cleared entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int h = 0; h < thb_pkg::NUM_HIST; h++) begin
				if (cfg_clr_mask[h] ||
				    (cmd.hist_clr && (m_q == thb_pkg::HIST_W'(h))))
					vld_q[h] <= '0;
			end
			if (cmd.rep_fin && is_rec)
				vld_q[m_q][b_q] <= 1'b1;
		end
	end

	// request, search and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			m_q   <= metric;
			val_q <= sample_value;
			amt_q <= add_amount;
			sel_q <= bucket_sel;
		end
		if (cmd.decode) begin
			lo_q         <= '0;
			hi_q         <= thb_pkg::BKT_W'(used - thb_pkg::USED_W'(1));
			b_q          <= sel_q;
			lower_bound  <= '0;
			upper_bound  <= '0;
			bucket_total <= '0;
			is_disabled  <= !on;
			bucket_index <= '0;
			if (!bad_m && (req_q == thb_pkg::REQ_WRITE ||
			               (req_q == thb_pkg::REQ_READ && on)))
				bucket_index <= sel_q;
		end
		if (cmd.srch_upd) begin
			if (val_q <= thr_rdata_q)
				hi_q <= mid;
			else
				lo_q <= mid + thb_pkg::BKT_W'(1);
		end
		if (cmd.srch_end)
			b_q <= hi_q;
		if (cmd.rep_rd_hi) begin
			lower_bound  <= (b_q == '0) ? '0 : thr_rdata_q + thb_pkg::DATA_W'(1);
			bucket_total <= cnt_cur + (is_rec ? amt_q : '0);
		end
		if (cmd.rep_fin) begin
			upper_bound  <= (b_next >= used) ? '1 : thr_rdata_q;
			bucket_index <= b_q;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/threshold_histogram_binner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_histogram_binner
// multi-histogram binner: binary search over threshold memory, 64-bit counters
// ----------------------------------------------------------------------------
// sequencing: a record request runs a binary search of at most 6 steps for
//   64 buckets before its bucket report. one item at a time, the next start is
//   taken the cycle after done; the threshold read port sets the pace.
// reset: asynchronous, clears controller state, configuration registers and
//   counter valid bits at once; no clearing pass. receiver cannot stall done.
module threshold_histogram_binner (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request channel
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       req_type,
	input  wire logic [1:0]                       metric,
	input  wire logic [63:0]                      sample_value,
	input  wire logic [63:0]                      add_amount,
	input  wire logic [5:0]                       bucket_sel,
	// result channel
	output logic                                  done,
	output logic [5:0]                            bucket_index,
	output logic [63:0]                           lower_bound,
	output logic [63:0]                           upper_bound,
	output logic [63:0]                           bucket_total,
	output logic                                  is_disabled,
	// configuration channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [thb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [thb_pkg::CFG_DATA_W-1:0]   cfg_data
);

	thb_pkg::thb_cmd_t  cmd;
	thb_pkg::thb_stat_t stat;

	// configuration registers
	logic [thb_pkg::NUM_HIST-1:0]                       en_q;
	logic [thb_pkg::NUM_HIST-1:0][thb_pkg::USED_W-1:0]  used_q;
	logic                                               cfg_beat;
	logic [thb_pkg::NUM_HIST-1:0]                       cfg_clr_mask;

	// config beats only land while no request is in flight
	assign cfg_ready = !busy;
	assign cfg_beat  = cfg_valid && cfg_ready;

	// a histogram that becomes enabled starts from zeroed counters
	assign cfg_clr_mask = (cfg_beat && cfg_index == thb_pkg::REG_ENABLE) ?
	                      (cfg_data[thb_pkg::NUM_HIST-1:0] & ~en_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= '0;
			used_q <= {thb_pkg::NUM_HIST{thb_pkg::USED_W'(1)}};
		end else if (cfg_beat) begin
			case (cfg_index)
				thb_pkg::REG_ENABLE: en_q      <= cfg_data[thb_pkg::NUM_HIST-1:0];
				thb_pkg::REG_USED0:  used_q[0] <= cfg_data;
				thb_pkg::REG_USED1:  used_q[1] <= cfg_data;
				thb_pkg::REG_USED2:  used_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: accepts start only when idle and steps the datapath through its commands
	thb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// memories, search window and result registers
	thb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.en_mask      (en_q),
		.used_cfg     (used_q),
		.cfg_clr_mask (cfg_clr_mask),
		.req_type     (req_type),
		.metric       (metric),
		.sample_value (sample_value),
		.add_amount   (add_amount),
		.bucket_sel   (bucket_sel),
		.bucket_index (bucket_index),
		.lower_bound  (lower_bound),
		.upper_bound  (upper_bound),
		.bucket_total (bucket_total),
		.is_disabled  (is_disabled)
	);

	// a result beat only comes out of a request in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat while idle");

	// an accepted request always occupies the block next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start");

	// exactly one result beat per request
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	// a disabled answer never carries bounds or totals
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_disabled) |->
		(lower_bound == '0 && upper_bound == '0 && bucket_total == '0))
		else $error("disabled result carries data");

endmodule
`default_nettype wire
